[sv/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ARENA_BYTES  = 1024;
  localparam int HEADER_BYTES = 24;
  localparam int AW           = $clog2(ARENA_BYTES);
  localparam int SW           = 12;

  // result codes
  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FREED   = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_BADOFF  = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef struct packed {
    logic          func;
    logic [SW-1:0] req_size;
    logic [AW-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [AW-1:0] payload_offset;
  } rsp_t;

  // block header as held in the arena memory
  typedef struct packed {
    logic          present;
    logic [SW-1:0] size;
    logic          is_free;
    logic          has_link;
    logic [AW-1:0] link;
  } hdr_t;

  localparam int HW = $bits(hdr_t);

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_OFF,
    RD_LINK
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_NEWHDR,
    WR_SPLIT,
    WR_TAKE,
    WR_FREE,
    WR_MERGE,
    WR_ZAP
  } wr_op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHK,
    S_A_WB,
    S_F_CHK,
    S_F_NCHK,
    S_F_ZAP,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    ld_req;
    rd_sel_e rd_sel;
    logic    ld_at;
    logic    ld_hdr;
    wr_op_e  wr_op;
    logic    clr_inc;
    logic    res_ld;
    status_e res_code;
    logic    out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic off_bad;
    logic present;
    logic fits;
    logic split;
    logic stop;
    logic merge;
    logic was_free;
  } flags_t;

endpackage

[sv/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/ffa_datapath.sv]
// ----------------------------------------------------------------------------
// ffa_datapath
// Header memory, walk pointer, header register, result and output registers.
// ----------------------------------------------------------------------------
module ffa_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ffa_pkg::req_t req_i,
  input  ffa_pkg::cmd_t cmd_i,
  output ffa_pkg::flags_t flags_o,
  output ffa_pkg::rsp_t rsp_o
);

  localparam logic [ffa_pkg::AW:0] HdrBytes = (ffa_pkg::AW+1)'(ffa_pkg::HEADER_BYTES);
  localparam logic [ffa_pkg::SW-1:0] HdrSz  = ffa_pkg::SW'(ffa_pkg::HEADER_BYTES);
  localparam logic [ffa_pkg::SW-1:0] InitSz =
    ffa_pkg::SW'(ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES);

  ffa_pkg::req_t             req_q;
  logic [ffa_pkg::AW-1:0]    at_q, at_d;
  ffa_pkg::hdr_t             hdr_q;
  logic [ffa_pkg::AW:0]      clr_q;
  ffa_pkg::rsp_t             res_q, out_q;
  ffa_pkg::hdr_t             rdata, wdata;
  logic [ffa_pkg::AW-1:0]    raddr, waddr;
  logic                      we;
  logic [ffa_pkg::SW:0]      rem;
  logic [ffa_pkg::SW+1:0]    nh_full;
  logic [ffa_pkg::AW-1:0]    nh;
  logic [ffa_pkg::AW:0]      off_ext;

  // header memory
  ffa_ram #(.WIDTH(ffa_pkg::HW), .DEPTH(ffa_pkg::ARENA_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // split arithmetic on the header just read
  assign rem     = {1'b0, rdata.size} - {1'b0, req_q.req_size};
  assign nh_full = (ffa_pkg::SW+2)'(at_q) + (ffa_pkg::SW+2)'(ffa_pkg::HEADER_BYTES)
                   + (ffa_pkg::SW+2)'(req_q.req_size);
  assign nh      = nh_full[ffa_pkg::AW-1:0];
  assign off_ext = {1'b0, req_i.free_offset} - HdrBytes;

  // status toward the controller
  always_comb begin
    flags_o.clr_done = (clr_q[ffa_pkg::AW-1:0] == '1);
    flags_o.off_bad  = ({1'b0, req_i.free_offset} < HdrBytes);
    flags_o.present  = rdata.present;
    flags_o.fits     = rdata.is_free && (rdata.size >= req_q.req_size);
    flags_o.split    = !rem[ffa_pkg::SW] && (rem[ffa_pkg::SW-1:0] >= HdrSz)
                       && (nh_full < (ffa_pkg::SW+2)'(ffa_pkg::ARENA_BYTES));
    flags_o.stop     = !rdata.has_link || (rdata.link <= at_q);
    flags_o.merge    = hdr_q.has_link && rdata.present && rdata.is_free;
    flags_o.was_free = hdr_q.is_free;
  end

  // read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      ffa_pkg::RD_ZERO: raddr = '0;
      ffa_pkg::RD_OFF:  raddr = off_ext[ffa_pkg::AW-1:0];
      ffa_pkg::RD_LINK: raddr = rdata.link;
      default:          raddr = '0;
    endcase
  end
  assign at_d = raddr;

  // write address and data select
  always_comb begin
    we    = 1'b1;
    waddr = at_q;
    wdata = rdata;
    unique case (cmd_i.wr_op)
      ffa_pkg::WR_NONE: begin
        we = 1'b0;
      end
      ffa_pkg::WR_CLEAR: begin
        waddr = clr_q[ffa_pkg::AW-1:0];
        wdata = '0;
        if (clr_q == '0) begin
          wdata.present = 1'b1;
          wdata.size    = InitSz;
          wdata.is_free = 1'b1;
        end
      end
      ffa_pkg::WR_NEWHDR: begin
        waddr         = nh;
        wdata.present = 1'b1;
        wdata.size    = rem[ffa_pkg::SW-1:0] - HdrSz;
        wdata.is_free = 1'b1;
      end
      ffa_pkg::WR_SPLIT: begin
        wdata          = hdr_q;
        wdata.size     = req_q.req_size;
        wdata.is_free  = 1'b0;
        wdata.has_link = 1'b1;
        wdata.link     = nh;
      end
      ffa_pkg::WR_TAKE: begin
        wdata.is_free = 1'b0;
      end
      ffa_pkg::WR_FREE: begin
        wdata         = hdr_q;
        wdata.is_free = 1'b1;
      end
      ffa_pkg::WR_MERGE: begin
        wdata.present  = 1'b1;
        wdata.size     = hdr_q.size + rdata.size + HdrSz;
        wdata.is_free  = 1'b1;
        wdata.has_link = rdata.has_link;
        wdata.link     = rdata.link;
      end
      ffa_pkg::WR_ZAP: begin
        waddr = hdr_q.link;
        wdata = '0;
      end
      default: we = 1'b0;
    endcase
  end

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_inc) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // request, walk pointer, header and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_q <= req_i;
    end
    if (cmd_i.ld_at) begin
      at_q <= at_d;
    end
    if (cmd_i.ld_hdr) begin
      hdr_q <= rdata;
    end
    if (cmd_i.res_ld) begin
      res_q.status         <= cmd_i.res_code;
      res_q.payload_offset <= (cmd_i.res_code == ffa_pkg::ST_GRANTED)
                              ? at_q + HdrBytes[ffa_pkg::AW-1:0] : '0;
    end
    if (cmd_i.out_ld) begin
      out_q <= res_q;
    end
  end

  assign rsp_o = out_q;

endmodule

[sv/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for the clear sweep, the allocate walk and the free/merge steps.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  ffa_pkg::req_t   req_i,
  output logic            req_stall_o,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  input  ffa_pkg::flags_t flags_i,
  output ffa_pkg::cmd_t   cmd_o
);

  ffa_pkg::state_e state_q, state_d;
  logic            rsp_valid_q, rsp_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffa_pkg::S_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = ffa_pkg::RD_ZERO;
    cmd_o.wr_op  = ffa_pkg::WR_NONE;
    cmd_o.res_code = ffa_pkg::ST_NOFIT;
    req_stall_o  = 1'b1;
    rsp_valid_d  = rsp_valid_q && rsp_stall_i;
    unique case (state_q)
      ffa_pkg::S_CLEAR: begin
        cmd_o.wr_op   = ffa_pkg::WR_CLEAR;
        cmd_o.clr_inc = 1'b1;
        if (flags_i.clr_done) state_d = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          cmd_o.ld_req = 1'b1;
          cmd_o.ld_at  = 1'b1;
          if (req_i.func == ffa_pkg::FUNC_ALLOC) begin
            cmd_o.rd_sel = ffa_pkg::RD_ZERO;
            state_d      = ffa_pkg::S_A_CHK;
          end else if (flags_i.off_bad) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_code = ffa_pkg::ST_BADOFF;
            state_d        = ffa_pkg::S_DONE;
          end else begin
            cmd_o.rd_sel = ffa_pkg::RD_OFF;
            state_d      = ffa_pkg::S_F_CHK;
          end
        end
      end
      ffa_pkg::S_A_CHK: begin
        cmd_o.ld_hdr = 1'b1;
        if (!flags_i.present) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = ffa_pkg::ST_NOFIT;
          state_d        = ffa_pkg::S_DONE;
        end else if (flags_i.fits) begin
          if (flags_i.split) begin
            cmd_o.wr_op = ffa_pkg::WR_NEWHDR;
            state_d     = ffa_pkg::S_A_WB;
          end else begin
            cmd_o.wr_op    = ffa_pkg::WR_TAKE;
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_code = ffa_pkg::ST_GRANTED;
            state_d        = ffa_pkg::S_DONE;
          end
        end else if (flags_i.stop) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = ffa_pkg::ST_NOFIT;
          state_d        = ffa_pkg::S_DONE;
        end else begin
          cmd_o.rd_sel = ffa_pkg::RD_LINK;
          cmd_o.ld_at  = 1'b1;
        end
      end
      ffa_pkg::S_A_WB: begin
        cmd_o.wr_op    = ffa_pkg::WR_SPLIT;
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_code = ffa_pkg::ST_GRANTED;
        state_d        = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_F_CHK: begin
        cmd_o.ld_hdr = 1'b1;
        if (!flags_i.present) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = ffa_pkg::ST_BADOFF;
          state_d        = ffa_pkg::S_DONE;
        end else begin
          cmd_o.rd_sel = ffa_pkg::RD_LINK;
          state_d      = ffa_pkg::S_F_NCHK;
        end
      end
      ffa_pkg::S_F_NCHK: begin
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_code = flags_i.was_free ? ffa_pkg::ST_DOUBLE : ffa_pkg::ST_FREED;
        if (flags_i.merge) begin
          cmd_o.wr_op = ffa_pkg::WR_MERGE;
          state_d     = ffa_pkg::S_F_ZAP;
        end else begin
          cmd_o.wr_op = ffa_pkg::WR_FREE;
          state_d     = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_F_ZAP: begin
        cmd_o.wr_op = ffa_pkg::WR_ZAP;
        state_d     = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_DONE: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          cmd_o.out_ld = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = ffa_pkg::S_IDLE;
        end
      end
      default: state_d = ffa_pkg::S_IDLE;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

  // no request taken during the clear sweep
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffa_pkg::S_CLEAR) |-> req_stall_o)
    else $error("request taken during clear sweep");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_stall_i) |-> !cmd_o.out_ld)
    else $error("pending result overwritten");

  // merge write is always followed by removal of the absorbed header
  a_merge_zap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_op == ffa_pkg::WR_MERGE) |=> (cmd_o.wr_op == ffa_pkg::WR_ZAP))
    else $error("merge without header removal");

endmodule

[sv/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a 1024-byte arena kept as a chain of headers.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid_i/req_i (allocate or free); each request gives
// exactly one result on rsp_valid_o/rsp_o. A transfer happens on a rising edge
// with valid high and stall low on that channel.
// After reset the block sweeps all 1024 entries of the header memory, one entry
// per cycle, with req_stall_o high; entry zero becomes one free block.
// Allocate: the request is issued, then each header visited is read (one
// memory read each), a split adds a step for the split header write, and the
// result is loaded into the output register. Free: the header is read, then the
// next one; a merge adds a step that removes the absorbed header. A bad offset
// ends at issue inside the first header, or after the read when none is found.
// One request is worked at a time; the next is taken once the result sits in
// the output register, even if the receiver still stalls it. A stalled
// result holds until taken, and a finished result waits for the register.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  ffa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output ffa_pkg::rsp_t rsp_o
);

  ffa_pkg::cmd_t   cmd;
  ffa_pkg::flags_t flags;

  // controller
  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_i       (req_i),
    .req_stall_o (req_stall_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // datapath
  ffa_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .flags_o (flags),
    .rsp_o   (rsp_o)
  );

  // a grant points past at least one header
  a_grant_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ffa_pkg::ST_GRANTED))
      |-> (rsp_o.payload_offset >= ffa_pkg::AW'(ffa_pkg::HEADER_BYTES)))
    else $error("grant offset inside header");

  // non-grant results carry a zero offset
  a_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != ffa_pkg::ST_GRANTED))
      |-> (rsp_o.payload_offset == '0))
    else $error("nonzero offset without grant");

  // status codes stay in range
  a_status_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status <= 3'(ffa_pkg::ST_BADOFF)))
    else $error("status out of range");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the first-fit block allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free requests, first from a short table and then at
// random, tracks its own image of the block chain and checks every result
// field by field in order. The sender works in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 750;
  localparam int MAX_CYCLE = 2_000_000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           req_stall_o;
  ffa_pkg::req_t  req_i = '0;
  logic           rsp_valid_o;
  logic           rsp_stall_i = 1'b0;
  ffa_pkg::rsp_t  rsp_o;

  first_fit_block_allocator i_dut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o
  );

  always #10 clk_i = ~clk_i;

  // image of the arena headers
  bit          hdr_here [ffa_pkg::ARENA_BYTES];
  int unsigned hdr_size [ffa_pkg::ARENA_BYTES];
  bit          hdr_free [ffa_pkg::ARENA_BYTES];
  bit          hdr_linked [ffa_pkg::ARENA_BYTES];
  int unsigned hdr_next [ffa_pkg::ARENA_BYTES];

  ffa_pkg::rsp_t results_due[$];
  int unsigned   granted[$];
  int            errors = 0;
  longint        cycle = 0;

  function automatic void arena_reset();
    for (int i = 0; i < ffa_pkg::ARENA_BYTES; i++) begin
      hdr_here[i] = 0; hdr_size[i] = 0; hdr_free[i] = 0;
      hdr_linked[i] = 0; hdr_next[i] = 0;
    end
    hdr_here[0] = 1;
    hdr_size[0] = ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES;
    hdr_free[0] = 1;
  endfunction

  function automatic ffa_pkg::rsp_t grant_first_fit(int unsigned want);
    ffa_pkg::rsp_t r;
    int unsigned   at;
    int unsigned   nh;
    at = 0;
    r.status = ffa_pkg::ST_NOFIT;
    r.payload_offset = '0;
    for (int s = 0; s < ffa_pkg::ARENA_BYTES; s++) begin
      if (at >= ffa_pkg::ARENA_BYTES || !hdr_here[at]) break;
      if (hdr_free[at] && hdr_size[at] >= want) begin
        if (hdr_size[at] - want >= ffa_pkg::HEADER_BYTES) begin
          nh = at + ffa_pkg::HEADER_BYTES + want;
          if (nh < ffa_pkg::ARENA_BYTES) begin
            hdr_here[nh] = 1;
            hdr_size[nh] = hdr_size[at] - want - ffa_pkg::HEADER_BYTES;
            hdr_free[nh] = 1;
            hdr_linked[nh] = hdr_linked[at];
            hdr_next[nh] = hdr_next[at];
            hdr_size[at] = want;
            hdr_linked[at] = 1;
            hdr_next[at] = nh;
          end
        end
        hdr_free[at] = 0;
        r.status = ffa_pkg::ST_GRANTED;
        r.payload_offset = ffa_pkg::AW'(at + ffa_pkg::HEADER_BYTES);
        return r;
      end
      if (!hdr_linked[at] || hdr_next[at] <= at) break;
      at = hdr_next[at];
    end
    return r;
  endfunction

  function automatic ffa_pkg::rsp_t release_block(int unsigned off);
    ffa_pkg::rsp_t r;
    int unsigned   at;
    int unsigned   nx;
    r.payload_offset = '0;
    r.status = ffa_pkg::ST_BADOFF;
    if (off < ffa_pkg::HEADER_BYTES) return r;
    at = off - ffa_pkg::HEADER_BYTES;
    if (!hdr_here[at]) return r;
    r.status = hdr_free[at] ? ffa_pkg::ST_DOUBLE : ffa_pkg::ST_FREED;
    hdr_free[at] = 1;
    if (hdr_linked[at] && hdr_next[at] < ffa_pkg::ARENA_BYTES
        && hdr_here[hdr_next[at]]) begin
      nx = hdr_next[at];
      if (hdr_free[nx]) begin
        hdr_size[at] = hdr_size[at] + hdr_size[nx] + ffa_pkg::HEADER_BYTES;
        hdr_linked[at] = hdr_linked[nx];
        hdr_next[at] = hdr_next[nx];
        hdr_here[nx] = 0; hdr_size[nx] = 0; hdr_free[nx] = 0;
        hdr_linked[nx] = 0; hdr_next[nx] = 0;
      end
    end
    return r;
  endfunction

  function automatic ffa_pkg::rsp_t predict_result(ffa_pkg::req_t q);
    ffa_pkg::rsp_t r;
    if (q.func == ffa_pkg::FUNC_ALLOC) begin
      r = grant_first_fit(q.req_size);
      if (r.status == ffa_pkg::ST_GRANTED) granted.push_back(r.payload_offset);
    end else begin
      r = release_block(q.free_offset);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle, what);
  endtask

  // send one request and queue its expected result
  task automatic send_request(ffa_pkg::req_t q, bit typed, ffa_pkg::rsp_t r_typed);
    ffa_pkg::rsp_t r;
    req_valid_i <= 1'b1;
    req_i <= q;
    do @(posedge clk_i); while (req_stall_o);
    r = predict_result(q);
    if (typed && r !== r_typed)
      report_mismatch($sformatf("table row disagrees with prediction st=%0d", r.status));
    results_due.push_back(typed ? r_typed : r);
  endtask

  // sender bursts and gaps
  int burst_left = 0;
  task automatic maybe_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        req_valid_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // receiver stall pattern
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall_i <= 1'b0;
      1: rsp_stall_i <= ($urandom_range(0, 3) == 0);
      2: rsp_stall_i <= ($urandom_range(0, 1) == 0);
      default: rsp_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        ffa_pkg::rsp_t e;
        e = results_due.pop_front();
        if (rsp_o.status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_o.status, e.status));
        if (rsp_o.payload_offset !== e.payload_offset)
          report_mismatch($sformatf("offset %0d, want %0d",
                                    rsp_o.payload_offset, e.payload_offset));
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle > MAX_CYCLE) begin
      $display("first_fit_block_allocator regression: fail");
      $finish;
    end
  end

  typedef struct {
    ffa_pkg::req_t q;
    bit            typed;
    ffa_pkg::rsp_t r;
  } row_t;

  function automatic row_t mk(bit fn, int unsigned sz, int unsigned off,
                              bit typed, ffa_pkg::status_e st, int unsigned po);
    row_t w;
    w.q.func = fn;
    w.q.req_size = ffa_pkg::SW'(sz);
    w.q.free_offset = ffa_pkg::AW'(off);
    w.typed = typed;
    w.r.status = st;
    w.r.payload_offset = ffa_pkg::AW'(po);
    return w;
  endfunction

  function automatic ffa_pkg::req_t random_request();
    ffa_pkg::req_t q;
    int unsigned   k;
    q.func = ffa_pkg::FUNC_ALLOC;
    q.req_size = '0;
    q.free_offset = '0;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      q.req_size = ($urandom_range(0, 3) == 0) ? ffa_pkg::SW'($urandom_range(0, 4095))
                                               : ffa_pkg::SW'($urandom_range(0, 120));
      q.free_offset = ffa_pkg::AW'($urandom);
    end else begin
      q.func = ffa_pkg::FUNC_FREE;
      q.req_size = ffa_pkg::SW'($urandom);
      if (k < 85 && granted.size() > 0)
        q.free_offset = ffa_pkg::AW'(granted[$urandom_range(0, granted.size() - 1)]);
      else
        q.free_offset = ffa_pkg::AW'($urandom);
    end
    return q;
  endfunction

  row_t table_rows[$];

  initial begin
    ffa_pkg::req_t q;
    arena_reset();
    // directed table: st/offset typed only where obvious
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 0, 1, ffa_pkg::ST_BADOFF, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 4095, 23, 1, ffa_pkg::ST_BADOFF, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 25, 1, ffa_pkg::ST_BADOFF, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 24, 1, ffa_pkg::ST_DOUBLE, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 4095, 1023, 1, ffa_pkg::ST_NOFIT, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 1001, 0, 1, ffa_pkg::ST_NOFIT, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 0, 0, 1, ffa_pkg::ST_GRANTED, 24));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 16, 0, 1, ffa_pkg::ST_GRANTED, 48));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 100, 0, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 48, 1, ffa_pkg::ST_FREED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 48, 1, ffa_pkg::ST_DOUBLE, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 10, 0, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 24, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 72, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 4000, 0, 1, ffa_pkg::ST_NOFIT, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 700, 0, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 300, 0, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_ALLOC, 0, 0, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 1023, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 24, 0, ffa_pkg::ST_GRANTED, 0));
    table_rows.push_back(mk(ffa_pkg::FUNC_FREE, 0, 72, 0, ffa_pkg::ST_GRANTED, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) begin
      maybe_gap();
      send_request(table_rows[i].q, table_rows[i].typed, table_rows[i].r);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      maybe_gap();
      q = random_request();
      send_request(q, 0, '0);
    end
    req_valid_i <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("first_fit_block_allocator regression: pass");
    end else begin
      $display("first_fit_block_allocator regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_datapath.sv
sv/ffa_ctrl.sv
sv/first_fit_block_allocator.sv
dv/tb_top.sv
